// ----- rtl/core/mhpq_pkg.sv -----
// Shared types and constants for the binary max-heap priority queue.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package mhpq_pkg;

  // stream payload layout
  localparam int unsigned OP_W       = 2;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned RESULT_W   = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 48;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_A,
    S_POP_B,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_PEEK_A,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_INS_START,
    DP_POP_START,
    DP_PEEK_START,
    DP_ERR_EMPTY,
    DP_ERR_FULL,
    DP_NOP,
    DP_UP_CHK,
    DP_UP_CMP,
    DP_POP_A,
    DP_POP_B,
    DP_DN_CHK,
    DP_DN_L,
    DP_DN_R,
    DP_PEEK_A,
    DP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic up_root;
    logic up_swap;
    logic dn_leaf;
    logic dn_has_right;
    logic dn_swap_l;
    logic dn_swap_r;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/max_heap_priority_queue.sv -----
// Binary max-heap priority queue, one operation per input transaction, one at a time.
// An insert sifts the new value up level by level; a pop moves the last element to the
// root and sifts it down, comparing with the left child and, if present, the right child.
// The result is loaded into the output register once the previous result is no longer held.
// Reset (async, active low) empties the heap, not the store. Needs mhpq_pkg, ctrl, dpath.
`default_nettype none

module max_heap_priority_queue #(
  parameter int unsigned CAPACITY   = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_tvalid_i,
  output logic                                   s_tready_o,
  input  wire logic [mhpq_pkg::S_TDATA_W-1:0]    s_tdata_i,  // operation[1:0], value[33:2]
  output logic                                   m_tvalid_o,
  input  wire logic                              m_tready_i,
  output logic [mhpq_pkg::M_TDATA_W-1:0]         m_tdata_o   // result_value[31:0],
                                                             // status[33:32],
                                                             // element_count[41:34]
);

  mhpq_pkg::cmd_t                  cmd;
  mhpq_pkg::sts_t                  sts;
  logic [mhpq_pkg::RESULT_W-1:0]   out_result;
  logic [mhpq_pkg::STATUS_W-1:0]   out_status;
  logic [mhpq_pkg::COUNT_W-1:0]    out_count;

  mhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_op_i    (s_tdata_i[mhpq_pkg::OP_W-1:0]),
    .in_ready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mhpq_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_value_i   (s_tdata_i[mhpq_pkg::OP_W +: mhpq_pkg::VALUE_W]),
    .sts_o        (sts),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_result_o (out_result),
    .out_status_o (out_status),
    .out_count_o  (out_count)
  );

  assign m_tdata_o = {6'd0, out_count, out_status, out_result};

`ifndef SYNTHESIS
  a_full_at_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && out_status == mhpq_pkg::STATUS_FULL |->
      out_count == mhpq_pkg::COUNT_W'(CAPACITY) && out_result == '0)
    else $error("full status with count below capacity");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && out_status == mhpq_pkg::STATUS_EMPTY |->
      out_count == '0 && out_result == '0)
    else $error("empty status with nonzero count or result");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("new transaction taken while an operation is in flight");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/mhpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/mhpq_ctrl.sv -----
// Controller state machine for the max-heap priority queue: sequences the
// sift-up and sift-down walks. Depends on mhpq_pkg.
`default_nettype none

module mhpq_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [mhpq_pkg::OP_W-1:0]     in_op_i,
  output logic                               in_ready_o,
  input  wire mhpq_pkg::sts_t                sts_i,
  output mhpq_pkg::cmd_t                     cmd_o
);

  mhpq_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_ready_o = (state_q == mhpq_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          case (in_op_i)
            mhpq_pkg::OP_INSERT: state_d = sts_i.full ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_CHK;
            mhpq_pkg::OP_POP:    state_d = sts_i.empty ? mhpq_pkg::S_DONE : mhpq_pkg::S_POP_A;
            mhpq_pkg::OP_PEEK:   state_d = sts_i.empty ? mhpq_pkg::S_DONE : mhpq_pkg::S_PEEK_A;
            default:             state_d = mhpq_pkg::S_DONE;
          endcase
        end
      end
      mhpq_pkg::S_UP_CHK: begin
        state_d = sts_i.up_root ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_CMP;
      end
      mhpq_pkg::S_UP_CMP: begin
        state_d = sts_i.up_swap ? mhpq_pkg::S_UP_CHK : mhpq_pkg::S_DONE;
      end
      mhpq_pkg::S_POP_A:  state_d = mhpq_pkg::S_POP_B;
      mhpq_pkg::S_POP_B:  state_d = mhpq_pkg::S_DN_CHK;
      mhpq_pkg::S_DN_CHK: begin
        state_d = sts_i.dn_leaf ? mhpq_pkg::S_DONE : mhpq_pkg::S_DN_L;
      end
      mhpq_pkg::S_DN_L: begin
        if (sts_i.dn_has_right) begin
          state_d = mhpq_pkg::S_DN_R;
        end else begin
          state_d = sts_i.dn_swap_l ? mhpq_pkg::S_DN_CHK : mhpq_pkg::S_DONE;
        end
      end
      mhpq_pkg::S_DN_R: begin
        state_d = sts_i.dn_swap_r ? mhpq_pkg::S_DN_CHK : mhpq_pkg::S_DONE;
      end
      mhpq_pkg::S_PEEK_A: state_d = mhpq_pkg::S_DONE;
      mhpq_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          state_d = mhpq_pkg::S_IDLE;
        end
      end
      default: state_d = mhpq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = mhpq_pkg::DP_NONE;
    case (state_q)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          case (in_op_i)
            mhpq_pkg::OP_INSERT:
              cmd_o.op = sts_i.full ? mhpq_pkg::DP_ERR_FULL : mhpq_pkg::DP_INS_START;
            mhpq_pkg::OP_POP:
              cmd_o.op = sts_i.empty ? mhpq_pkg::DP_ERR_EMPTY : mhpq_pkg::DP_POP_START;
            mhpq_pkg::OP_PEEK:
              cmd_o.op = sts_i.empty ? mhpq_pkg::DP_ERR_EMPTY : mhpq_pkg::DP_PEEK_START;
            default:
              cmd_o.op = mhpq_pkg::DP_NOP;
          endcase
        end
      end
      mhpq_pkg::S_UP_CHK: cmd_o.op = mhpq_pkg::DP_UP_CHK;
      mhpq_pkg::S_UP_CMP: cmd_o.op = mhpq_pkg::DP_UP_CMP;
      mhpq_pkg::S_POP_A:  cmd_o.op = mhpq_pkg::DP_POP_A;
      mhpq_pkg::S_POP_B:  cmd_o.op = mhpq_pkg::DP_POP_B;
      mhpq_pkg::S_DN_CHK: cmd_o.op = mhpq_pkg::DP_DN_CHK;
      mhpq_pkg::S_DN_L:   cmd_o.op = mhpq_pkg::DP_DN_L;
      mhpq_pkg::S_DN_R:   cmd_o.op = mhpq_pkg::DP_DN_R;
      mhpq_pkg::S_PEEK_A: cmd_o.op = mhpq_pkg::DP_PEEK_A;
      mhpq_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = mhpq_pkg::DP_OUT_LOAD;
        end
      end
      default: cmd_o.op = mhpq_pkg::DP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mhpq_dpath.sv -----
// Datapath for the max-heap priority queue: heap store, count, walk
// position, carried value, compares and the output register.
// Depends on mhpq_pkg and mhpq_ram.
`default_nettype none

module mhpq_dpath #(
  parameter int unsigned CAPACITY   = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mhpq_pkg::cmd_t                    cmd_i,
  input  wire logic [mhpq_pkg::VALUE_W-1:0]      in_value_i,
  output mhpq_pkg::sts_t                         sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [mhpq_pkg::RESULT_W-1:0]          out_result_o,
  output logic [mhpq_pkg::STATUS_W-1:0]          out_status_o,
  output logic [mhpq_pkg::COUNT_W-1:0]           out_count_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = IW + 2;

  logic [CW-1:0]                   cnt_q, cnt_d;
  logic [IW-1:0]                   pos_q, pos_d;
  logic [DATA_WIDTH-1:0]           val_q, val_d;
  logic [DATA_WIDTH-1:0]           lv_q, lv_d;
  logic [mhpq_pkg::RESULT_W-1:0]   res_q, res_d;
  mhpq_pkg::status_e               stat_q, stat_d;
  logic                            out_valid_q, out_valid_d;
  logic [mhpq_pkg::RESULT_W-1:0]   out_res_q, out_res_d;
  logic [mhpq_pkg::STATUS_W-1:0]   out_stat_q, out_stat_d;
  logic [mhpq_pkg::COUNT_W-1:0]    out_cnt_q, out_cnt_d;

  logic                            ram_we;
  logic [IW-1:0]                   ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0]           ram_wdata, ram_rdata;

  logic [LW-1:0]                   left_w, right_w, cnt_w;
  logic [IW-1:0]                   parent_w, best_idx;
  logic [DATA_WIDTH-1:0]           best_v, in_val;
  logic                            right_wins;
  logic [mhpq_pkg::RESULT_W-1:0]   rd_ext;

  mhpq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign left_w     = LW'({pos_q, 1'b1});
  assign right_w    = left_w + LW'(1);
  assign cnt_w      = LW'(cnt_q);
  assign parent_w   = (pos_q - IW'(1)) >> 1;
  assign right_wins = $signed(lv_q) < $signed(ram_rdata);
  assign best_v     = right_wins ? ram_rdata : lv_q;
  assign best_idx   = right_wins ? right_w[IW-1:0] : left_w[IW-1:0];
  assign in_val     = DATA_WIDTH'($signed(in_value_i));
  assign rd_ext     = mhpq_pkg::RESULT_W'($signed(ram_rdata));

  always_comb begin
    sts_o.empty        = (cnt_q == '0);
    sts_o.full         = (cnt_q == CW'(CAPACITY));
    sts_o.up_root      = (pos_q == '0);
    sts_o.up_swap      = $signed(ram_rdata) < $signed(val_q);
    sts_o.dn_leaf      = (left_w >= cnt_w);
    sts_o.dn_has_right = (right_w < cnt_w);
    sts_o.dn_swap_l    = $signed(val_q) < $signed(ram_rdata);
    sts_o.dn_swap_r    = $signed(val_q) < $signed(best_v);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  always_comb begin
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    val_d       = val_q;
    lv_d        = lv_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = val_q;
    ram_raddr   = '0;
    case (cmd_i.op)
      mhpq_pkg::DP_INS_START: begin
        pos_d  = cnt_q[IW-1:0];
        cnt_d  = cnt_q + CW'(1);
        val_d  = in_val;
        res_d  = '0;
        stat_d = mhpq_pkg::STATUS_OK;
      end
      mhpq_pkg::DP_POP_START: begin
        cnt_d  = cnt_q - CW'(1);
        stat_d = mhpq_pkg::STATUS_OK;
      end
      mhpq_pkg::DP_PEEK_START: begin
        stat_d = mhpq_pkg::STATUS_OK;
      end
      mhpq_pkg::DP_ERR_EMPTY: begin
        res_d  = '0;
        stat_d = mhpq_pkg::STATUS_EMPTY;
      end
      mhpq_pkg::DP_ERR_FULL: begin
        res_d  = '0;
        stat_d = mhpq_pkg::STATUS_FULL;
      end
      mhpq_pkg::DP_NOP: begin
        res_d  = '0;
        stat_d = mhpq_pkg::STATUS_OK;
      end
      mhpq_pkg::DP_UP_CHK: begin
        if (pos_q == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = parent_w;
        end
      end
      mhpq_pkg::DP_UP_CMP: begin
        ram_we = 1'b1;
        if (sts_o.up_swap) begin
          ram_wdata = ram_rdata;
          pos_d     = parent_w;
        end
      end
      mhpq_pkg::DP_POP_A: begin
        res_d     = rd_ext;
        ram_raddr = cnt_q[IW-1:0];
      end
      mhpq_pkg::DP_POP_B: begin
        val_d = ram_rdata;
        pos_d = '0;
      end
      mhpq_pkg::DP_DN_CHK: begin
        if (sts_o.dn_leaf) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = left_w[IW-1:0];
        end
      end
      mhpq_pkg::DP_DN_L: begin
        lv_d = ram_rdata;
        if (sts_o.dn_has_right) begin
          ram_raddr = right_w[IW-1:0];
        end else begin
          ram_we = 1'b1;
          if (sts_o.dn_swap_l) begin
            ram_wdata = ram_rdata;
            pos_d     = left_w[IW-1:0];
          end
        end
      end
      mhpq_pkg::DP_DN_R: begin
        ram_we = 1'b1;
        if (sts_o.dn_swap_r) begin
          ram_wdata = best_v;
          pos_d     = best_idx;
        end
      end
      mhpq_pkg::DP_PEEK_A: begin
        res_d = rd_ext;
      end
      mhpq_pkg::DP_OUT_LOAD: begin
        out_valid_d = 1'b1;
        out_res_d   = res_q;
        out_stat_d  = stat_q;
        out_cnt_d   = mhpq_pkg::COUNT_W'(cnt_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    val_q      <= val_d;
    lv_q       <= lv_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    out_res_q  <= out_res_d;
    out_stat_q <= out_stat_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_res_q;
  assign out_status_o = out_stat_q;
  assign out_count_o  = out_cnt_q;

endmodule

`default_nettype wire

// ----- tb/sv/max_heap_priority_queue_tb.sv -----
// Self-checking testbench for max_heap_priority_queue: random operation streams with
// stalls on both sides, checked against a behavioral max-heap kept in the bench.
// Depends on mhpq_pkg and the max_heap_priority_queue RTL.
`timescale 1ns / 100ps

module max_heap_priority_queue_tb;

  localparam int unsigned CAP        = 128;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned LIMIT      = 1000000;
  localparam int unsigned ITEMS      = 1500;
  localparam int unsigned HOLD_AT    = 400;
  localparam int unsigned HOLD_LEN   = 600;

  typedef struct packed {
    logic signed [mhpq_pkg::RESULT_W-1:0] value;
    mhpq_pkg::status_e                    status;
    logic [mhpq_pkg::COUNT_W-1:0]         count;
  } heap_answer_t;

  typedef struct {
    logic [mhpq_pkg::OP_W-1:0]    op;
    logic [mhpq_pkg::VALUE_W-1:0] value;
    bit                           drain;
  } heap_req_t;

  logic                           clk_i      = 1'b0;
  logic                           rst_ni     = 1'b0;
  logic                           s_tvalid_i = 1'b0;
  logic                           s_tready_o;
  logic [mhpq_pkg::S_TDATA_W-1:0] s_tdata_i  = '0;
  logic                           m_tvalid_o;
  logic                           m_tready_i = 1'b0;
  logic [mhpq_pkg::M_TDATA_W-1:0] m_tdata_o;

  heap_req_t    op_q[$];
  heap_answer_t answer_q[$];

  logic signed [mhpq_pkg::VALUE_W-1:0] heap_arr [CAP];
  int unsigned               heap_cnt  = 0;
  bit                        s_fire    = 1'b0;
  int unsigned               src_gap   = 0;
  int unsigned               rx_gap    = 0;
  int unsigned               hold_left = 0;
  bit                        hold_done = 1'b0;
  int unsigned               rx_cnt    = 0;
  int unsigned               errors    = 0;
  int unsigned               cycles    = 0;

  max_heap_priority_queue #(
    .CAPACITY  (CAP),
    .DATA_WIDTH(32)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit quiet_now();
    int unsigned n;
    n = op_q.size();
    return (n <= QUIET_TAIL) || (n >= 700 && n < 800);
  endfunction

  function automatic heap_answer_t heap_op_apply(
      input logic [mhpq_pkg::OP_W-1:0] op,
      input logic signed [mhpq_pkg::VALUE_W-1:0] v);
    heap_answer_t                        a;
    int unsigned                         pos, par, lft, big;
    logic signed [mhpq_pkg::VALUE_W-1:0] t;
    bit                                  done;
    a.value  = '0;
    a.status = mhpq_pkg::STATUS_OK;
    case (op)
      mhpq_pkg::OP_INSERT: begin
        if (heap_cnt >= CAP) begin
          a.status = mhpq_pkg::STATUS_FULL;
        end else begin
          heap_arr[heap_cnt] = v;
          pos = heap_cnt;
          heap_cnt++;
          done = 1'b0;
          while (pos > 0 && !done) begin
            par = (pos - 1) / 2;
            if (heap_arr[par] < heap_arr[pos]) begin
              t = heap_arr[par];
              heap_arr[par] = heap_arr[pos];
              heap_arr[pos] = t;
              pos = par;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
      mhpq_pkg::OP_POP: begin
        if (heap_cnt == 0) begin
          a.status = mhpq_pkg::STATUS_EMPTY;
        end else begin
          a.value = heap_arr[0];
          heap_cnt--;
          heap_arr[0] = heap_arr[heap_cnt];
          pos = 0;
          done = 1'b0;
          while (!done) begin
            lft = 2 * pos + 1;
            if (lft >= heap_cnt) begin
              done = 1'b1;
            end else begin
              big = lft;
              if (lft + 1 < heap_cnt && heap_arr[lft] < heap_arr[lft+1]) big = lft + 1;
              if (heap_arr[pos] < heap_arr[big]) begin
                t = heap_arr[pos];
                heap_arr[pos] = heap_arr[big];
                heap_arr[big] = t;
                pos = big;
              end else begin
                done = 1'b1;
              end
            end
          end
        end
      end
      mhpq_pkg::OP_PEEK: begin
        if (heap_cnt == 0) a.status = mhpq_pkg::STATUS_EMPTY;
        else a.value = heap_arr[0];
      end
      default: ;
    endcase
    a.count = heap_cnt[mhpq_pkg::COUNT_W-1:0];
    return a;
  endfunction

  // sender: holds tdata until accepted, then picks the next item or a gap
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid_i || s_fire)) begin
      if (src_gap != 0) begin
        src_gap = src_gap - 1;
        s_tvalid_i <= 1'b0;
      end else if (op_q.size() != 0 && !(op_q[0].drain && answer_q.size() != 0)) begin
        s_tvalid_i <= 1'b1;
        s_tdata_i  <= {6'b0, op_q[0].value, op_q[0].op};
        void'(op_q.pop_front());
        if (!quiet_now() && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 15);
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && rx_cnt >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_tready_i <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap = rx_gap - 1;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
        if (!quiet_now() && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 15);
      end
    end
  end

  // monitor: predicts on input transactions, checks output transactions
  always @(posedge clk_i) begin
    heap_answer_t want, got;
    if (rst_ni) begin
      s_fire <= s_tvalid_i && s_tready_o;
      if (s_tvalid_i && s_tready_o)
        answer_q.push_back(heap_op_apply(s_tdata_i[1:0], s_tdata_i[33:2]));
      if (m_tvalid_o && m_tready_i) begin
        rx_cnt++;
        got.value  = m_tdata_o[31:0];
        got.status = mhpq_pkg::status_e'(m_tdata_o[33:32]);
        got.count  = m_tdata_o[41:34];
        if (answer_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transaction: value %0d status %0d count %0d",
                     got.value, got.status, got.count);
        end else begin
          want = answer_q.pop_front();
          if (got.value !== want.value || got.status !== want.status ||
              got.count !== want.count) begin
            errors++;
            if (errors <= 10)
              $display("mismatch #%0d: exp value %0d status %0d count %0d, got %0d %0d %0d",
                       rx_cnt, want.value, want.status, want.count,
                       got.value, got.status, got.count);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_req(input logic [mhpq_pkg::OP_W-1:0] op,
                          input logic [mhpq_pkg::VALUE_W-1:0] v,
                          input bit drain = 1'b0);
    heap_req_t r;
    r.op    = op;
    r.value = v;
    r.drain = drain;
    op_q.push_back(r);
  endtask

  function automatic logic [mhpq_pkg::VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      5, 6, 7: return $urandom_range(0, 15) - 8;
      8: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned total, mode, len, r, k;
    logic [mhpq_pkg::OP_W-1:0] op;

    // directed: empty errors, unused code, extremes, ties
    push_req(mhpq_pkg::OP_PEEK, 32'h1234_5678);
    push_req(mhpq_pkg::OP_POP, 32'hffff_ffff);
    push_req(2'd3, 32'hdead_beef);
    push_req(mhpq_pkg::OP_INSERT, 32'h7fff_ffff);
    push_req(mhpq_pkg::OP_INSERT, 32'h8000_0000);
    push_req(mhpq_pkg::OP_INSERT, 32'h0000_0000);
    push_req(mhpq_pkg::OP_INSERT, 32'hffff_ffff);
    push_req(mhpq_pkg::OP_INSERT, 32'h0000_0001);
    push_req(mhpq_pkg::OP_INSERT, 32'h0000_0005);
    push_req(mhpq_pkg::OP_INSERT, 32'h0000_0005);
    push_req(mhpq_pkg::OP_INSERT, 32'h0000_0005);
    push_req(mhpq_pkg::OP_PEEK, 32'hffff_ffff);
    push_req(2'd3, 32'hffff_ffff);
    for (k = 0; k < 9; k++) push_req(mhpq_pkg::OP_POP, 32'h0);
    push_req(mhpq_pkg::OP_INSERT, 32'haaaa_aaaa);
    push_req(mhpq_pkg::OP_INSERT, 32'h5555_5555);
    push_req(mhpq_pkg::OP_PEEK, 32'h0);
    total = op_q.size();

    // drain to empty, then fill past capacity, sender paused first
    for (k = 0; k < 6; k++) push_req(mhpq_pkg::OP_POP, rand_value(), k == 0);
    for (k = 0; k < CAP + 8; k++) push_req(mhpq_pkg::OP_INSERT, rand_value(), k == 0);
    for (k = 0; k < 6; k++)
      push_req($urandom_range(0, 1) ? mhpq_pkg::OP_PEEK : mhpq_pkg::OP_POP, rand_value());
    total += 12 + CAP + 8;

    while (total < ITEMS) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(20, 120);
      for (k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: op = r < 70 ? mhpq_pkg::OP_INSERT : r < 88 ? mhpq_pkg::OP_POP :
                  r < 97 ? mhpq_pkg::OP_PEEK : 2'd3;
          1: op = r < 22 ? mhpq_pkg::OP_INSERT : r < 85 ? mhpq_pkg::OP_POP :
                  r < 97 ? mhpq_pkg::OP_PEEK : 2'd3;
          default: op = r < 45 ? mhpq_pkg::OP_INSERT : r < 85 ? mhpq_pkg::OP_POP :
                        r < 97 ? mhpq_pkg::OP_PEEK : 2'd3;
        endcase
        push_req(op, rand_value(), k == 0 && $urandom_range(0, 3) == 0);
        if (op != 2'd3) total++;
      end
    end

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (op_q.size() != 0 || s_tvalid_i) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_ram.sv
rtl/core/mhpq_ctrl.sv
rtl/core/mhpq_dpath.sv
rtl/core/max_heap_priority_queue.sv
tb/sv/max_heap_priority_queue_tb.sv
